// ----- rtl/bcfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bcfe_pkg: shared types and constants of the block cache
// Field widths, operation and register codes, stream packing, cell control.
// ----------------------------------------------------------------------------
package bcfe_pkg;

	localparam int OP_W     = 2;
	localparam int TAG_W    = 32;
	localparam int WIDX_IN_W = 6;
	localparam int DATA_W   = 64;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;

	// Input stream: op, block_number, word_index, data_word (104 bits, whole bytes)
	localparam int IN_TDATA_W  = 104;
	// Output stream: read_word, status, zero fill to 72 bits
	localparam int OUT_TDATA_W = 72;

	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_BLOCK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT  = 1'd1;

	localparam logic [CFG_W-1:0] WORDS_RESET    = 7'd64;
	localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd51;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_MISS = 1'b1;

	// Per-cell control: drop marks the cell to remove, load marks the insert cell
	typedef struct packed {
		logic drop;
		logic load;
	} cell_ctl_t;

endpackage

// ----- rtl/bcfe_cell.sv -----
// ----------------------------------------------------------------------------
// bcfe_cell: one entry of the age-ordered tag chain
// Holds valid, tag and memory row; shifts down from its upper neighbor on a drop.
// ----------------------------------------------------------------------------
module bcfe_cell
	import bcfe_pkg::*;
#(
	parameter int SLOT_W = 6,
	parameter int INDEX  = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [TAG_W-1:0]  key,
	input  logic              above_in,
	output logic              above_out,
	input  logic              nb_valid,
	input  logic [TAG_W-1:0]  nb_tag,
	input  logic [SLOT_W-1:0] nb_slot,
	output logic              valid,
	output logic [TAG_W-1:0]  tag,
	output logic [SLOT_W-1:0] slot,
	output logic              match
);

	logic              valid_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SLOT_W-1:0] slot_q;
	logic              shift;

	// cells at or above the dropped one take their neighbor's contents
	assign above_out = above_in | ctl.drop;
	assign shift     = above_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= SLOT_W'(INDEX);
		end else if (shift) begin
			valid_q <= nb_valid;
			slot_q  <= nb_slot;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= nb_tag;
		end else if (ctl.load) begin
			tag_q <= key;
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign slot  = slot_q;
	assign match = valid_q && (tag_q == key);

endmodule

// ----- rtl/block_cache_fifo_evict.sv -----
// ----------------------------------------------------------------------------
// block_cache_fifo_evict: fully associative disk block cache, FIFO eviction
// A chain of tag cells kept in insertion order plus a block word memory.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: op, block_number, word_index, data_word
// m_*       out  m_tvalid/m_tready  m_tdata: read_word, status; m_tlast: last
// cfg_*     in   cfg_we             cfg_index, cfg_data (7 bits)
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Read hit: after the match and decide steps, each word takes a memory read, then
//   an output register load; the read waits while the output register is full.
// Miss and delete pass through the match and decide steps; an unused op goes straight to its result.
// Write of word 0 inserts the row, then the memory's single write port zeroes
//   the remaining words of the new row. Later words are written in place.
// Reset clears the chain, count and fill tracking at once; no clearing pass.
// A stalled m_tready holds the result register; the next item is still taken.
// ----------------------------------------------------------------------------
module block_cache_fifo_evict
	import bcfe_pkg::*;
#(
	parameter int ENTRIES   = 64,
	parameter int MAX_WORDS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[1:0], block_number[33:2], word_index[39:34], data_word[103:40]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // read_word[63:0], status[64], zero fill
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int NW_W   = $clog2(MAX_WORDS + 1);
	localparam int DEPTH  = ENTRIES * MAX_WORDS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_EVICT  = 4'd1;
	localparam logic [3:0] ST_MATCH  = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_DROP   = 4'd4;
	localparam logic [3:0] ST_INS    = 4'd5;
	localparam logic [3:0] ST_CLR    = 4'd6;
	localparam logic [3:0] ST_WORD   = 4'd7;
	localparam logic [3:0] ST_RD_ISS = 4'd8;
	localparam logic [3:0] ST_RD_WT  = 4'd9;
	localparam logic [3:0] ST_EMIT   = 4'd10;

	logic [3:0] state_q;

	// configuration
	logic [CFG_W-1:0] wpb_q;
	logic [CFG_W-1:0] cap_q;

	// latched item
	logic [OP_W-1:0]      op_q;
	logic [TAG_W-1:0]     key_q;
	logic [WIDX_IN_W-1:0] widx_q;
	logic [DATA_W-1:0]    data_q;

	logic [CNT_W-1:0]  count_q;
	logic [ENTRIES-1:0] hit_s1;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [NW_W-1:0]   rd_idx_q;
	logic [WIDX_W-1:0] clr_idx_q;
	logic              emit_st_q;

	// fill tracking for later words of a block
	logic              fill_ok_q;
	logic [SLOT_W-1:0] fill_slot_q;
	logic [TAG_W-1:0]  fill_tag_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_word_q;
	logic              out_st_q;
	logic              out_last_q;
	logic              out_free;

	// chain
	cell_ctl_t          ctl [ENTRIES];
	logic [ENTRIES:0]   above;
	logic [ENTRIES-1:0] c_valid;
	logic [TAG_W-1:0]   c_tag  [ENTRIES];
	logic [SLOT_W-1:0]  c_slot [ENTRIES];
	logic [ENTRIES-1:0] c_match;
	logic [ENTRIES-1:0] sel_vec;
	logic [SLOT_W-1:0]  sel_slot;
	logic [SLOT_W-1:0]  ins_slot;

	// memory
	logic [DATA_W-1:0] mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] rdata_q;

	logic [NW_W-1:0]  nw;
	logic [CNT_W-1:0] lim;
	logic             word_ok;
	logic             rd_last;
	logic             in_xfer;
	logic             out_load;
	logic [DATA_W-1:0] out_word_d;
	logic             out_st_d;
	logic             out_last_d;

	function automatic logic [ADDR_W-1:0] mk_addr(input logic [SLOT_W-1:0] s,
			input logic [WIDX_W-1:0] w);
		mk_addr = ADDR_W'(s) * ADDR_W'(MAX_WORDS) + ADDR_W'(w);
	endfunction

	// clamp registers to their working ranges
	always_comb begin
		if (wpb_q == '0) begin
			nw = NW_W'(1);
		end else if (32'(wpb_q) > MAX_WORDS) begin
			nw = NW_W'(MAX_WORDS);
		end else begin
			nw = NW_W'(wpb_q);
		end
		if (cap_q == '0) begin
			lim = CNT_W'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			lim = CNT_W'(ENTRIES);
		end else begin
			lim = CNT_W'(cap_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign word_ok = (32'(widx_q) < 32'(nw)) && fill_ok_q && (fill_tag_q == key_q);
	assign rd_last = ((rd_idx_q + NW_W'(1)) == nw);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpb_q <= WORDS_RESET;
			cap_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WORDS_PER_BLOCK: wpb_q <= cfg_data;
				REG_CAPACITY_LIMIT:  cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// drop vector: oldest cell on eviction, the hit cell on a drop
	always_comb begin
		sel_vec = '0;
		if (state_q == ST_EVICT) begin
			sel_vec[0] = 1'b1;
		end else begin
			sel_vec = hit_s1;
		end
	end

	always_comb begin
		sel_slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			sel_slot = sel_slot | ({SLOT_W{sel_vec[i]}} & c_slot[i]);
		end
	end

	assign ins_slot = c_slot[count_q[SLOT_W-1:0]];
	assign above[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			logic              nb_valid;
			logic [TAG_W-1:0]  nb_tag;
			logic [SLOT_W-1:0] nb_slot;

			assign ctl[g].drop = ((state_q == ST_EVICT) || (state_q == ST_DROP)) && sel_vec[g];
			assign ctl[g].load = (state_q == ST_INS) && (count_q == CNT_W'(g));

			if (g == ENTRIES - 1) begin : g_tail
				// the dropped row wraps to the free end of the chain
				assign nb_valid = 1'b0;
				assign nb_tag   = '0;
				assign nb_slot  = sel_slot;
			end else begin : g_body
				assign nb_valid = c_valid[g+1];
				assign nb_tag   = c_tag[g+1];
				assign nb_slot  = c_slot[g+1];
			end

			bcfe_cell #(
				.SLOT_W (SLOT_W),
				.INDEX  (g)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl[g]),
				.key       (key_q),
				.above_in  (above[g]),
				.above_out (above[g+1]),
				.nb_valid  (nb_valid),
				.nb_tag    (nb_tag),
				.nb_slot   (nb_slot),
				.valid     (c_valid[g]),
				.tag       (c_tag[g]),
				.slot      (c_slot[g]),
				.match     (c_match[g])
			);
		end
	endgenerate

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = mk_addr(fill_slot_q, clr_idx_q);
		mem_wdata = '0;
		unique case (state_q)
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = mk_addr(ins_slot, '0);
				mem_wdata = data_q;
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_WORD: begin
				mem_we    = word_ok;
				mem_waddr = mk_addr(fill_slot_q, WIDX_W'(widx_q));
				mem_wdata = data_q;
			end
			default: ;
		endcase
	end

	assign mem_re    = (state_q == ST_RD_ISS) && out_free;
	assign mem_raddr = mk_addr(rd_slot_q, WIDX_W'(rd_idx_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// item latch and match register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= s_tdata[1:0];
			key_q  <= s_tdata[33:2];
			widx_q <= s_tdata[39:34];
			data_q <= s_tdata[103:40];
		end
		if (state_q == ST_MATCH) begin
			hit_s1 <= c_match;
		end
		if (state_q == ST_DECIDE) begin
			rd_slot_q <= sel_slot;
		end
	end

	// result to be loaded into the output register
	always_comb begin
		out_load   = 1'b0;
		out_word_d = '0;
		out_st_d   = emit_st_q;
		out_last_d = 1'b1;
		if (state_q == ST_RD_WT) begin
			out_load   = 1'b1;
			out_word_d = rdata_q;
			out_st_d   = STATUS_OK;
			out_last_d = rd_last;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_load = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			fill_ok_q   <= 1'b0;
			fill_slot_q <= '0;
			fill_tag_q  <= '0;
			emit_st_q   <= STATUS_OK;
			rd_idx_q    <= '0;
			clr_idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						rd_idx_q <= '0;
						if (s_tdata[1:0] == OP_READ || s_tdata[1:0] == OP_DELETE) begin
							state_q <= ST_MATCH;
						end else if (s_tdata[1:0] == OP_WRITE) begin
							if (s_tdata[39:34] != '0) begin
								state_q <= ST_WORD;
							end else if (count_q >= lim) begin
								state_q <= ST_EVICT;
							end else begin
								state_q <= ST_MATCH;
							end
						end else begin
							emit_st_q <= STATUS_MISS;
							state_q   <= ST_EMIT;
						end
					end
				end
				ST_EVICT: begin
					count_q <= count_q - CNT_W'(1);
					if (sel_slot == fill_slot_q) begin
						fill_ok_q <= 1'b0;
					end
					state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (hit_s1 != '0) begin
						state_q <= (op_q == OP_READ) ? ST_RD_ISS : ST_DROP;
					end else if (op_q == OP_WRITE) begin
						state_q <= ST_INS;
					end else begin
						emit_st_q <= STATUS_MISS;
						state_q   <= ST_EMIT;
					end
				end
				ST_DROP: begin
					count_q <= count_q - CNT_W'(1);
					if (sel_slot == fill_slot_q) begin
						fill_ok_q <= 1'b0;
					end
					if (op_q == OP_WRITE) begin
						state_q <= ST_INS;
					end else begin
						emit_st_q <= STATUS_OK;
						state_q   <= ST_EMIT;
					end
				end
				ST_INS: begin
					count_q     <= count_q + CNT_W'(1);
					fill_ok_q   <= 1'b1;
					fill_slot_q <= ins_slot;
					fill_tag_q  <= key_q;
					clr_idx_q   <= WIDX_W'(1);
					emit_st_q   <= STATUS_OK;
					state_q     <= (MAX_WORDS > 1) ? ST_CLR : ST_EMIT;
				end
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + WIDX_W'(1);
					if (32'(clr_idx_q) == MAX_WORDS - 1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_WORD: begin
					emit_st_q <= word_ok ? STATUS_OK : STATUS_MISS;
					state_q   <= ST_EMIT;
				end
				ST_RD_ISS: begin
					if (out_free) begin
						state_q <= ST_RD_WT;
					end
				end
				ST_RD_WT: begin
					rd_idx_q <= rd_idx_q + NW_W'(1);
					state_q  <= rd_last ? ST_IDLE : ST_RD_ISS;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: hold until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= out_word_d;
			out_st_q   <= out_st_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - DATA_W - 1){1'b0}}, out_st_q, out_word_q};
	assign m_tlast  = out_last_q;

	// chain bookkeeping checks
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(c_valid) == 32'(count_q))
		else $error("entry count disagrees with valid cells");

	assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid + ENTRIES'(1)) & c_valid) == '0)
		else $error("valid cells are not packed from the oldest end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> $onehot0(hit_s1))
		else $error("more than one cell matched a tag");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (32'(count_q) < ENTRIES))
		else $error("insert with a full chain");

endmodule

// ----- tb/tb_block_cache_fifo_evict.sv -----
// ----------------------------------------------------------------------------
// tb_block_cache_fifo_evict: self-checking bench for the block cache
// Drives stream items, predicts every result with a behavioral cache model
// and compares each whole result (word, status, last) at once, in order.
// ----------------------------------------------------------------------------
module tb_block_cache_fifo_evict;
	import bcfe_pkg::*;

	localparam int NSLOT = 64;
	localparam int NWORD = 64;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [63:0] data_word;
		logic [5:0]  word_index;
		logic [31:0] block_number;
		logic [1:0]  op;
	} cache_req_t;

	typedef struct packed {
		logic [63:0] read_word;
		logic        status;
		logic        last;
	} cache_rsp_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	block_cache_fifo_evict dut (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// model state of the cache
	logic        slot_valid [NSLOT];
	logic [31:0] slot_tag [NSLOT];
	int          slot_rank [NSLOT];
	logic [63:0] slot_data [NSLOT][NWORD];
	int          live_count, last_fill;
	logic [6:0]  words_reg, limit_reg;

	cache_req_t  pending_reqs[$];
	cache_rsp_t  expected_rsps[$];
	int  mismatches = 0;
	bit  timed_out = 0;
	bit  send_quiet = 0, recv_quiet = 0, hold_recv = 0;
	bit  in_taken = 0;
	int  send_gap = 0, recv_gap = 0, idle_cycles = 0;
	logic [31:0] tag_pool [8];

	function automatic int slot_of(logic [31:0] tag);
		for (int s = 0; s < NSLOT; s++)
			if (slot_valid[s] && slot_tag[s] == tag) return s;
		return -1;
	endfunction

	function automatic void remove_slot(int s);
		for (int k = 0; k < NSLOT; k++)
			if (slot_valid[k] && slot_rank[k] > slot_rank[s]) slot_rank[k]--;
		slot_valid[s] = 1'b0;
		if (live_count > 0) live_count--;
	endfunction

	function automatic void push_rsp(logic [63:0] w, logic st, logic lst);
		cache_rsp_t r;
		r.read_word = w; r.status = st; r.last = lst;
		expected_rsps.push_back(r);
	endfunction

	// predict results of one accepted item and update the model
	function automatic void predict_access(cache_req_t q);
		int nw, lim, s, oldest;
		nw = (words_reg == 0) ? 1 : (words_reg > NWORD) ? NWORD : int'(words_reg);
		lim = (limit_reg == 0) ? 1 : (limit_reg > NSLOT) ? NSLOT : int'(limit_reg);
		case (q.op)
			OP_READ: begin
				s = slot_of(q.block_number);
				if (s < 0) push_rsp('0, STATUS_MISS, 1'b1);
				else for (int i = 0; i < nw; i++)
					push_rsp(slot_data[s][i], STATUS_OK, i == nw - 1);
			end
			OP_WRITE: begin
				if (q.word_index == 0) begin
					if (live_count >= lim) begin
						oldest = -1;
						for (int k = 0; k < NSLOT; k++)
							if (slot_valid[k] && (oldest < 0 || slot_rank[k] < slot_rank[oldest]))
								oldest = k;
						if (oldest >= 0) remove_slot(oldest);
					end
					s = slot_of(q.block_number);
					if (s >= 0) remove_slot(s);
					s = -1;
					for (int k = NSLOT - 1; k >= 0; k--) if (!slot_valid[k]) s = k;
					if (s < 0) push_rsp('0, STATUS_MISS, 1'b1);
					else begin
						slot_valid[s] = 1'b1;
						slot_tag[s] = q.block_number;
						slot_rank[s] = live_count;
						live_count++;
						last_fill = s;
						for (int i = 0; i < NWORD; i++) slot_data[s][i] = '0;
						slot_data[s][0] = q.data_word;
						push_rsp('0, STATUS_OK, 1'b1);
					end
				end else if (q.word_index < nw && slot_valid[last_fill]
						&& slot_tag[last_fill] == q.block_number) begin
					slot_data[last_fill][q.word_index] = q.data_word;
					push_rsp('0, STATUS_OK, 1'b1);
				end else push_rsp('0, STATUS_MISS, 1'b1);
			end
			OP_DELETE: begin
				s = slot_of(q.block_number);
				if (s < 0) push_rsp('0, STATUS_MISS, 1'b1);
				else begin
					remove_slot(s);
					push_rsp('0, STATUS_OK, 1'b1);
				end
			end
			default: push_rsp('0, STATUS_MISS, 1'b1);
		endcase
	endfunction

	function automatic void queue_access(logic [1:0] op, logic [31:0] tag, logic [5:0] idx,
			logic [63:0] data);
		cache_req_t q;
		q.op = op; q.block_number = tag; q.word_index = idx; q.data_word = data;
		pending_reqs.push_back(q);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// queue a whole block insert: word 0, then the rest in order
	function automatic void queue_block(logic [31:0] tag, int nw);
		for (int i = 0; i < nw; i++) queue_access(OP_WRITE, tag, 6'(i), rand_word());
	endfunction

	// remember whether the offered item was taken at the last rising edge
	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
	end

	// driver: present items at the falling edge, hold until the transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			// hold the offered item
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 1'b0;
		end else if (!send_quiet && $urandom_range(0, 9) == 0) begin
			send_gap <= $urandom_range(1, 17) - 1;
			s_tvalid <= 1'b0;
		end else if (pending_reqs.size() > 0) begin
			s_tdata <= pending_reqs.pop_front();
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver back-pressure, including the long hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_recv) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if (!recv_quiet && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		cache_rsp_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_access(cache_req_t'(s_tdata));
			if (m_tvalid && m_tready) begin
				got.read_word = m_tdata[63:0];
				got.status = m_tdata[64];
				got.last = m_tlast;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: word exp %h got %h, status exp %b got %b, last exp %b got %b",
								want.read_word, got.read_word, want.status, got.status,
								want.last, got.last);
					end
				end
			end
		end
	end

	// watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_recv)
			idle_cycles <= 0;
		else if (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_tvalid)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WORDS_PER_BLOCK) words_reg = val; else limit_reg = val;
	endtask

	// random phase: mostly well-formed inserts and accesses over a small tag pool
	task automatic random_phase(int n, int max_words);
		logic [31:0] tag;
		for (int i = 0; i < n; i++) begin
			tag = ($urandom_range(0, 9) == 0) ? $urandom : tag_pool[$urandom_range(0, 7)];
			case ($urandom_range(0, 9))
				0, 1, 2: queue_block(tag, $urandom_range(1, max_words));
				3, 4, 5: queue_access(OP_READ, tag, 6'($urandom), rand_word());
				6: queue_access(OP_DELETE, tag, 6'($urandom), rand_word());
				7: queue_access(OP_WRITE, tag, 6'($urandom_range(1, 63)), rand_word());
				8: queue_access(2'd3, tag, 6'($urandom), rand_word());
				default: queue_access(OP_READ, tag_pool[0], '0, '0);
			endcase
		end
	endtask

	initial begin
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		for (int s = 0; s < NSLOT; s++) begin
			slot_valid[s] = 1'b0; slot_tag[s] = '0; slot_rank[s] = 0;
		end
		live_count = 0; last_fill = 0;
		words_reg = WORDS_RESET; limit_reg = CAPACITY_RESET;
		for (int i = 0; i < 8; i++) tag_pool[i] = $urandom;
		tag_pool[0] = 32'h0; tag_pool[1] = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: small blocks, extremes of fields and every special case
		write_reg(REG_WORDS_PER_BLOCK, 7'd4);
		write_reg(REG_CAPACITY_LIMIT, 7'd2);
		queue_access(OP_READ, 32'h0, 6'd0, '0);                  // miss on empty cache
		queue_access(OP_WRITE, 32'h0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_access(OP_WRITE, 32'h0, 6'd3, 64'h0);
		queue_access(OP_WRITE, 32'h0, 6'd63, 64'h1);             // word beyond block
		queue_access(OP_WRITE, 32'h5, 6'd1, 64'h2);              // later word, no insert
		queue_access(OP_READ, 32'h0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF); // unwritten words zero
		queue_block(32'hFFFF_FFFF, 4);
		queue_block(32'h1234_5678, 2);                           // evicts oldest
		queue_access(OP_READ, 32'h0, '0, '0);
		queue_block(32'hFFFF_FFFF, 1);                           // re-insert same tag
		queue_access(OP_READ, 32'hFFFF_FFFF, '0, '0);
		queue_access(OP_DELETE, 32'h1234_5678, '0, '0);
		queue_access(OP_DELETE, 32'h1234_5678, '0, '0);          // delete miss
		queue_access(2'd3, 32'hA5A5_A5A5, 6'h2A, 64'h5555_AAAA_5555_AAAA); // unused op
		queue_access(OP_READ, 32'hFFFF_FFFF, '0, '0);
		wait_drained();

		// register extremes: zero acts as one, above range clamps
		write_reg(REG_WORDS_PER_BLOCK, 7'd0);
		write_reg(REG_CAPACITY_LIMIT, 7'd0);
		queue_block(tag_pool[2], 2);
		queue_block(tag_pool[3], 1);
		queue_access(OP_READ, tag_pool[3], '0, '0);
		wait_drained();
		write_reg(REG_WORDS_PER_BLOCK, 7'd127);
		write_reg(REG_CAPACITY_LIMIT, 7'd127);
		queue_access(OP_WRITE, tag_pool[4], 6'd0, rand_word());
		queue_access(OP_WRITE, tag_pool[4], 6'd63, rand_word()); // top word of a full block
		queue_access(OP_READ, tag_pool[4], '0, '0);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		write_reg(REG_WORDS_PER_BLOCK, 7'd3);
		hold_recv = 1'b1;
		random_phase(10, 3);
		repeat (400) @(posedge clk);
		hold_recv = 1'b0;
		wait_drained();

		// random phases with a few settings, small blocks mostly
		write_reg(REG_CAPACITY_LIMIT, 7'd3);
		random_phase(20, 3);
		wait_drained();
		write_reg(REG_WORDS_PER_BLOCK, 7'd8);
		write_reg(REG_CAPACITY_LIMIT, 7'd64);
		random_phase(15, 8);
		wait_drained();
		write_reg(REG_WORDS_PER_BLOCK, 7'd1);
		write_reg(REG_CAPACITY_LIMIT, 7'd1);
		send_quiet = 1'b1; recv_quiet = 1'b1;                     // no idling at the end
		random_phase(15, 1);
		wait_drained();

		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
